[hdl/pmsm_current_reference_assert.svh]
// assertion macros shared by the checker
`ifndef PMSM_CURRENT_REFERENCE_ASSERT_SVH
`define PMSM_CURRENT_REFERENCE_ASSERT_SVH

// same-cycle implication
`define PCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("current reference assertion failed");

// implication after a fixed number of cycles
`define PCR_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("current reference latency assertion failed");

`endif

[hdl/pcr_pkg.sv]
package pcr_pkg;

    localparam int QUO_W       = 31;
    localparam int DIV_NUM_W   = 88;
    localparam int DIV_DEN_W   = 64;
    localparam int DIV_LAT     = QUO_W + 1;

    localparam int ROOT_W      = 31;
    localparam int SQRT_RAD_W  = 2 * ROOT_W;
    localparam int SQ_REM_W    = ROOT_W + 4;
    localparam int SQRT_LAT    = ROOT_W + 1;

    // plain register stages around the dividers and the root unit
    localparam int PLAIN_STAGES = 15;
    localparam int PCR_LAT      = 5 * DIV_LAT + SQRT_LAT + PLAIN_STAGES;

    localparam logic [2:0] CFG_MAX_POWER       = 3'd0;
    localparam logic [2:0] CFG_MAX_TORQUE      = 3'd1;
    localparam logic [2:0] CFG_NOMINAL_VOLTAGE = 3'd2;
    localparam logic [2:0] CFG_POLE_PAIRS      = 3'd3;
    localparam logic [2:0] CFG_FLUX_LINKAGE    = 3'd4;
    localparam logic [2:0] CFG_D_INDUCTANCE    = 3'd5;
    localparam logic [2:0] CFG_MAX_CURRENT     = 3'd6;
    localparam logic [2:0] CFG_BASE_SPEED      = 3'd7;

    typedef struct packed {
        logic signed [31:0] tr;
        logic signed [31:0] ms;
        logic signed [31:0] we;
        logic [30:0]        vbus;
        logic               zdm;
        logic               prod_zero;
        logic [30:0]        bound;
        logic signed [31:0] tc;
        logic signed [31:0] iq;
        logic               id_zero;
        logic               id_neg;
        logic signed [31:0] id;
    } t_item;

endpackage

[hdl/pcr_div.sv]
module pcr_div import pcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    input  t_item                i_item,
    output logic                 o_valid,
    output logic [QUO_W-1:0]     o_quo,
    output t_item                o_item
);

    logic [QUO_W:0]         r_vld;
    logic [QUO_W:0]         r_over;
    logic [DIV_DEN_W-1:0]   r_rem  [0:QUO_W];
    logic [DIV_DEN_W-1:0]   r_den  [0:QUO_W];
    logic [QUO_W-1:0]       r_low  [0:QUO_W];
    logic [QUO_W-1:0]       r_q    [0:QUO_W];
    t_item                  r_item [0:QUO_W];

    logic [DIV_DEN_W-1:0]   n_rem  [1:QUO_W];
    logic [QUO_W-1:0]       n_low  [1:QUO_W];
    logic [QUO_W-1:0]       n_q    [1:QUO_W];

    // one quotient bit per stage; quotient at or above 2^31 saturates
    always_comb begin
        logic [DIV_DEN_W:0] sh;
        for (int k = 1; k <= QUO_W; k++) begin
            sh       = {r_rem[k-1], r_low[k-1][QUO_W-1]};
            n_low[k] = {r_low[k-1][QUO_W-2:0], 1'b0};
            if (sh >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = DIV_DEN_W'(sh - {1'b0, r_den[k-1]});
                n_q[k]   = {r_q[k-1][QUO_W-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[DIV_DEN_W-1:0];
                n_q[k]   = {r_q[k-1][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QUO_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_over[0] <= (DIV_DEN_W'(i_num[DIV_NUM_W-1:QUO_W]) >= i_den);
        r_rem[0]  <= DIV_DEN_W'(i_num[DIV_NUM_W-1:QUO_W]);
        r_low[0]  <= i_num[QUO_W-1:0];
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_item[0] <= i_item;
        for (int k = 1; k <= QUO_W; k++) begin
            r_over[k] <= r_over[k-1];
            r_rem[k]  <= n_rem[k];
            r_low[k]  <= n_low[k];
            r_den[k]  <= r_den[k-1];
            r_q[k]    <= n_q[k];
            r_item[k] <= r_item[k-1];
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo   = r_over[QUO_W] ? '1 : r_q[QUO_W];
    assign o_item  = r_item[QUO_W];

endmodule

[hdl/pcr_sqrt.sv]
module pcr_sqrt import pcr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [SQRT_RAD_W-1:0] i_rad,
    input  t_item                 i_item,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output t_item                 o_item
);

    logic [ROOT_W:0]         r_vld;
    logic [SQ_REM_W-1:0]     r_rem  [0:ROOT_W];
    logic [SQRT_RAD_W-1:0]   r_x    [0:ROOT_W];
    logic [ROOT_W-1:0]       r_root [0:ROOT_W];
    t_item                   r_item [0:ROOT_W];

    logic [SQ_REM_W-1:0]     n_rem  [1:ROOT_W];
    logic [SQRT_RAD_W-1:0]   n_x    [1:ROOT_W];
    logic [ROOT_W-1:0]       n_root [1:ROOT_W];

    // two radicand bits and one root bit per stage
    always_comb begin
        logic [SQ_REM_W-1:0] sh;
        logic [SQ_REM_W-1:0] trial;
        for (int k = 1; k <= ROOT_W; k++) begin
            sh     = {r_rem[k-1][SQ_REM_W-3:0], r_x[k-1][SQRT_RAD_W-1:SQRT_RAD_W-2]};
            trial  = SQ_REM_W'({r_root[k-1], 2'b01});
            n_x[k] = {r_x[k-1][SQRT_RAD_W-3:0], 2'b00};
            if (sh >= trial) begin
                n_rem[k]  = sh - trial;
                n_root[k] = {r_root[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = sh;
                n_root[k] = {r_root[k-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROOT_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_x[0]    <= i_rad;
        r_root[0] <= '0;
        r_item[0] <= i_item;
        for (int k = 1; k <= ROOT_W; k++) begin
            r_rem[k]  <= n_rem[k];
            r_x[k]    <= n_x[k];
            r_root[k] <= n_root[k];
            r_item[k] <= r_item[k-1];
        end
    end

    assign o_valid = r_vld[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_item  = r_item[ROOT_W];

endmodule

[hdl/pmsm_current_reference.sv]
// PMSM current reference: one item is taken per clock whenever o_busy is low (it is
// high only during reset and the cycle after), and its result appears on the output
// ports for one cycle with o_valid, in order, after passing through a pipeline of
// five pipelined dividers of 32 stages each (speed floor, torque over speed, bus
// voltage scaling, q current, field weakening d current), a 32 stage square root
// for the current circle and fifteen plain register stages. The output cannot be
// stalled, so the receiver must take every result when it is shown.
// Configuration may only be written while no item is in flight.
module pmsm_current_reference import pcr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_torque_request,
    input  logic signed [31:0] i_mech_speed,
    input  logic signed [31:0] i_elec_speed,
    input  logic [30:0]        i_bus_voltage,
    output logic               o_valid,
    output logic signed [31:0] o_id_ref,
    output logic signed [31:0] o_iq_ref,
    output logic signed [31:0] o_torque_clamped,
    output logic signed [31:0] o_torque_bound,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic        r_busy;
    logic [30:0] r_max_power, r_max_torque, r_nominal_voltage, r_max_current, r_base_speed;
    logic [6:0]  r_pole_pairs;
    logic [31:0] r_flux, r_d_inductance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_power       <= '0;
            r_max_torque      <= 31'd65536;
            r_nominal_voltage <= 31'd65536;
            r_pole_pairs      <= 7'd1;
            r_flux            <= 32'd42949673;
            r_d_inductance    <= 32'd42949673;
            r_max_current     <= '0;
            r_base_speed      <= '0;
        end else if (i_cfg_valid && !r_busy) begin
            case (i_cfg_index)
                CFG_MAX_POWER:       r_max_power       <= i_cfg_data[30:0];
                CFG_MAX_TORQUE:      r_max_torque      <= i_cfg_data[30:0];
                CFG_NOMINAL_VOLTAGE: r_nominal_voltage <= i_cfg_data[30:0];
                CFG_POLE_PAIRS:      r_pole_pairs      <= i_cfg_data[6:0];
                CFG_FLUX_LINKAGE:    r_flux            <= i_cfg_data;
                CFG_D_INDUCTANCE:    r_d_inductance    <= i_cfg_data;
                CFG_MAX_CURRENT:     r_max_current     <= i_cfg_data[30:0];
                CFG_BASE_SPEED:      r_base_speed      <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // stage valid bits
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    logic r_h_vld, r_i_vld, r_j_vld, r_k_vld, r_l_vld, r_m_vld, r_n_vld, r_o_vld;
    logic w1_vld, w2_vld, w3_vld, w4_vld, w5_vld, w6_vld;

    t_item r_a_item, r_b_item, r_c_item, r_d_item, r_e_item, r_f_item, r_g_item;
    t_item r_h_item, r_i_item, r_j_item, r_k_item, r_l_item, r_m_item, r_n_item;
    t_item n_a_item, n_d_item, n_e_item, n_g_item, n_i_item, n_l_item;
    t_item w1_item, w2_item, w3_item, w4_item, w5_item, w6_item;

    logic [QUO_W-1:0]  w1_quo, w2_quo, w3_quo, w4_quo, w5_quo;
    logic [ROOT_W-1:0] w6_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0; r_b_vld <= 1'b0; r_c_vld <= 1'b0; r_d_vld <= 1'b0;
            r_e_vld <= 1'b0; r_f_vld <= 1'b0; r_g_vld <= 1'b0; r_h_vld <= 1'b0;
            r_i_vld <= 1'b0; r_j_vld <= 1'b0; r_k_vld <= 1'b0; r_l_vld <= 1'b0;
            r_m_vld <= 1'b0; r_n_vld <= 1'b0; r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= i_start && !r_busy;
            r_b_vld <= w1_vld;
            r_c_vld <= w2_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= w3_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= w4_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
            r_k_vld <= r_j_vld;
            r_l_vld <= w5_vld;
            r_m_vld <= r_l_vld;
            r_n_vld <= r_m_vld;
            r_o_vld <= w6_vld;
        end
    end

    // entry
    always_comb begin
        n_a_item      = '0;
        n_a_item.tr   = i_torque_request;
        n_a_item.ms   = i_mech_speed;
        n_a_item.we   = i_elec_speed;
        n_a_item.vbus = i_bus_voltage;
        n_a_item.zdm  = (i_mech_speed < $signed({1'b0, r_base_speed}));
    end

    always_ff @(posedge i_clk) begin
        r_a_item <= n_a_item;
    end

    // speed floor: power over max torque
    pcr_div u_div_floor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .i_num   (DIV_NUM_W'({r_max_power, 16'b0})),
        .i_den   (DIV_DEN_W'(r_max_torque)),
        .i_item  (r_a_item),
        .o_valid (w1_vld),
        .o_quo   (w1_quo),
        .o_item  (w1_item)
    );

    logic [31:0] n_b_magms, n_b_w, r_b_w;

    assign n_b_magms = w1_item.ms[31] ? (~w1_item.ms + 32'd1) : w1_item.ms;
    assign n_b_w     = (n_b_magms > 32'(w1_quo)) ? n_b_magms : 32'(w1_quo);

    always_ff @(posedge i_clk) begin
        r_b_item <= w1_item;
        r_b_w    <= n_b_w;
    end

    // torque available from power at this speed
    pcr_div u_div_tmin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (DIV_NUM_W'({r_max_power, 16'b0})),
        .i_den   (DIV_DEN_W'(r_b_w)),
        .i_item  (r_b_item),
        .o_valid (w2_vld),
        .o_quo   (w2_quo),
        .o_item  (w2_item)
    );

    logic [30:0] r_c_tmin;
    logic [61:0] n_d_prod, r_d_prod;

    always_ff @(posedge i_clk) begin
        r_c_item <= w2_item;
        r_c_tmin <= (w2_quo > r_max_torque) ? r_max_torque : w2_quo;
    end

    assign n_d_prod = r_c_item.vbus * r_c_tmin;

    always_comb begin
        n_d_item           = r_c_item;
        n_d_item.prod_zero = (r_c_item.vbus == '0) || (r_c_tmin == '0);
    end

    always_ff @(posedge i_clk) begin
        r_d_item <= n_d_item;
        r_d_prod <= n_d_prod;
    end

    // scale by bus voltage over nominal
    pcr_div u_div_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_vld),
        .i_num   (DIV_NUM_W'(r_d_prod)),
        .i_den   (DIV_DEN_W'(r_nominal_voltage)),
        .i_item  (r_d_item),
        .o_valid (w3_vld),
        .o_quo   (w3_quo),
        .o_item  (w3_item)
    );

    always_comb begin
        logic [30:0]        bnd;
        logic signed [32:0] tr33;
        logic signed [32:0] b33;
        bnd  = w3_item.prod_zero ? '0 : w3_quo;
        tr33 = {w3_item.tr[31], w3_item.tr};
        b33  = $signed({2'b00, bnd});
        n_e_item       = w3_item;
        n_e_item.bound = bnd;
        if (tr33 > b33) begin
            n_e_item.tc = $signed({1'b0, bnd});
        end else if (tr33 < -b33) begin
            n_e_item.tc = -$signed({1'b0, bnd});
        end else begin
            n_e_item.tc = w3_item.tr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_item <= n_e_item;
    end

    logic [31:0] n_f_magtc;
    logic [38:0] n_f_pp;
    logic [30:0] r_f_magtc;
    logic [40:0] r_f_den;

    assign n_f_magtc = r_e_item.tc[31] ? (~r_e_item.tc + 32'd1) : r_e_item.tc;
    assign n_f_pp    = r_pole_pairs * r_flux;

    always_ff @(posedge i_clk) begin
        r_f_item  <= r_e_item;
        r_f_magtc <= n_f_magtc[30:0];
        r_f_den   <= 41'({n_f_pp, 1'b0}) + 41'(n_f_pp);
    end

    // q current from torque
    pcr_div u_div_iq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_vld),
        .i_num   (DIV_NUM_W'({r_f_magtc, 33'b0})),
        .i_den   (DIV_DEN_W'(r_f_den)),
        .i_item  (r_f_item),
        .o_valid (w4_vld),
        .o_quo   (w4_quo),
        .o_item  (w4_item)
    );

    logic [37:0] r_g_pb;

    always_comb begin
        logic [31:0] mag;
        mag = (w4_item.tc == '0) ? '0 : 32'(w4_quo);
        n_g_item    = w4_item;
        n_g_item.iq = w4_item.tc[31] ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge i_clk) begin
        r_g_item <= n_g_item;
        r_g_pb   <= r_pole_pairs * r_base_speed;
    end

    logic signed [39:0] r_h_diff;
    logic [31:0]        r_h_magwe;

    always_ff @(posedge i_clk) begin
        r_h_item  <= r_g_item;
        r_h_diff  <= $signed({2'b00, r_g_pb}) - $signed({{8{r_g_item.we[31]}}, r_g_item.we});
        r_h_magwe <= r_g_item.we[31] ? (~r_g_item.we + 32'd1) : r_g_item.we;
    end

    logic [39:0] n_i_ndiff;
    logic [38:0] r_i_magdiff;
    logic [63:0] r_i_dd, r_j_dd, r_k_dd;

    assign n_i_ndiff = -r_h_diff;

    always_comb begin
        n_i_item         = r_h_item;
        n_i_item.id_zero = (r_h_diff == '0) || (r_flux == '0);
        n_i_item.id_neg  = r_h_diff[39] != r_h_item.we[31];
    end

    always_ff @(posedge i_clk) begin
        r_i_item    <= n_i_item;
        r_i_magdiff <= r_h_diff[39] ? n_i_ndiff[38:0] : r_h_diff[38:0];
        r_i_dd      <= r_h_magwe * r_d_inductance;
    end

    // wide numerator in two partial products
    logic [63:0] r_j_lo;
    logic [38:0] r_j_hi;
    logic [70:0] r_k_num;

    always_ff @(posedge i_clk) begin
        r_j_item <= r_i_item;
        r_j_lo   <= r_i_magdiff[31:0] * r_flux;
        r_j_hi   <= r_i_magdiff[38:32] * r_flux;
        r_j_dd   <= r_i_dd;
        r_k_item <= r_j_item;
        r_k_num  <= 71'(r_j_lo) + {r_j_hi, 32'b0};
        r_k_dd   <= r_j_dd;
    end

    // field weakening d current
    pcr_div u_div_id (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_k_vld),
        .i_num   ({r_k_num, 17'b0}),
        .i_den   (r_k_dd),
        .i_item  (r_k_item),
        .o_valid (w5_vld),
        .o_quo   (w5_quo),
        .o_item  (w5_item)
    );

    always_comb begin
        logic [31:0]        mag;
        logic signed [31:0] ids;
        logic signed [31:0] nimax;
        mag   = w5_item.id_zero ? '0 : 32'(w5_quo);
        ids   = w5_item.id_neg ? -$signed(mag) : $signed(mag);
        nimax = -$signed({1'b0, r_max_current});
        n_l_item    = w5_item;
        n_l_item.id = (ids < nimax) ? nimax : ids;
    end

    always_ff @(posedge i_clk) begin
        r_l_item <= n_l_item;
    end

    logic [31:0] n_m_magid;
    logic [61:0] r_m_isq, r_m_sq, r_n_rad;

    assign n_m_magid = r_l_item.id[31] ? (~r_l_item.id + 32'd1) : r_l_item.id;

    always_ff @(posedge i_clk) begin
        r_m_item <= r_l_item;
        r_m_isq  <= n_m_magid[30:0] * n_m_magid[30:0];
        r_m_sq   <= r_max_current * r_max_current;
        r_n_item <= r_m_item;
        r_n_rad  <= (r_m_isq >= r_m_sq) ? '0 : (r_m_sq - r_m_isq);
    end

    // current circle limit
    pcr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_n_vld),
        .i_rad   (r_n_rad),
        .i_item  (r_n_item),
        .o_valid (w6_vld),
        .o_root  (w6_root),
        .o_item  (w6_item)
    );

    logic signed [31:0] r_o_id, r_o_iq, r_o_tc, r_o_bound;

    always_ff @(posedge i_clk) begin
        logic [30:0]        lim;
        logic signed [32:0] l33;
        logic signed [32:0] iq33;
        lim  = w6_item.zdm ? r_max_current : w6_root;
        l33  = $signed({2'b00, lim});
        iq33 = {w6_item.iq[31], w6_item.iq};
        if (iq33 > l33) begin
            r_o_iq <= $signed({1'b0, lim});
        end else if (iq33 < -l33) begin
            r_o_iq <= -$signed({1'b0, lim});
        end else begin
            r_o_iq <= w6_item.iq;
        end
        r_o_id    <= w6_item.zdm ? '0 : w6_item.id;
        r_o_tc    <= w6_item.tc;
        r_o_bound <= $signed({1'b0, w6_item.bound});
    end

    assign o_valid          = r_o_vld;
    assign o_id_ref         = r_o_id;
    assign o_iq_ref         = r_o_iq;
    assign o_torque_clamped = r_o_tc;
    assign o_torque_bound   = r_o_bound;

endmodule

[hdl/pcr_checker.sv]
`include "pmsm_current_reference_assert.svh"

module pcr_port_checker import pcr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input logic signed [31:0] o_torque_clamped,
    input logic signed [31:0] o_torque_bound
);

    logic clamp_ok;

    assign clamp_ok = !o_torque_bound[31] && (o_torque_clamped <= o_torque_bound)
                      && (o_torque_clamped >= -o_torque_bound);

    // every accepted item comes out after the fixed latency
    `PCR_ASSERT_DLY(a_lat, i_clk, i_rst_n, i_start && !o_busy, PCR_LAT, o_valid)

    // no result without an item accepted the same latency earlier
    `PCR_ASSERT_IMP(a_src, i_clk, i_rst_n, o_valid, $past(i_start && !o_busy, PCR_LAT))

    // clamped torque stays inside a non-negative bound
    `PCR_ASSERT_IMP(a_clamp, i_clk, i_rst_n, o_valid, clamp_ok)

endmodule

bind pmsm_current_reference pcr_port_checker u_pcr_checker (.*);
